### sv/color_to_rgb565_converter_core_assert.svh
// Assertion macros shared by the color converter RTL.
`ifndef COLOR_TO_RGB565_CONVERTER_CORE_ASSERT_SVH
`define COLOR_TO_RGB565_CONVERTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define C2R_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define C2R_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define C2R_ASSERT(label, prop, msg)
`define C2R_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### sv/c2r_pkg.sv
// Shared types, constants and helpers of the color to RGB565 converter.
`default_nettype none
package c2r_pkg;

	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_UNIT      = 60 << HUE_FRAC_BITS;
	localparam int HUE_WRAP      = 360 << HUE_FRAC_BITS;
	localparam int SEC_MAX       = 65535 / HUE_UNIT;
	localparam int SECW          = $clog2(SEC_MAX + 1);
	localparam int FRACW         = $clog2(HUE_UNIT + 1);
	localparam int HSV_DEN       = 255 * HUE_UNIT;

	localparam logic [2:0] SEC_LAST = 3'd5;

	localparam logic [1:0] OP_HSV  = 2'd0;
	localparam logic [1:0] OP_HSL  = 2'd1;
	localparam logic [1:0] OP_MIX  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	// Both denominators are 3825 times a power of two. The quotient is
	// floor(x * RECIP_CORE / 2^34), exact for any x below 2^21.
	localparam int DIVW               = 21;
	localparam logic [22:0] RECIP_CORE = 23'd4491470;
	localparam int RECIP_SHIFT        = 34;
	localparam int HSV_PRE_SHIFT      = 8;
	localparam int HSL_PRE_SHIFT      = 9;

	// floor(x / 255) is floor(x * 0x8081 / 2^23) for any 16-bit x.
	localparam logic [15:0] RECIP_255 = 16'h8081;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  sec;
		logic [7:0]  val;
		logic [15:0] mix;
	} c2r_ctl_t;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RECIP_255);
		return p[30:23];
	endfunction

endpackage
`default_nettype wire

### sv/c2r_front.sv
// First two pipeline stages: hue sector, chroma and the per-mode products.
`default_nettype none
module c2r_front (
	input  logic                 clk,
	input  logic                 ld1,
	input  logic                 ld2,
	input  logic [1:0]           opcode,
	input  logic [15:0]          hue,
	input  logic [7:0]           saturation,
	input  logic [7:0]           brightness,
	input  logic [15:0]          base_color,
	input  logic [15:0]          extra_color,
	input  logic [7:0]           mix_ratio,
	output c2r_pkg::c2r_ctl_t    ctl_s2,
	output logic [19:0]          sf_s2,
	output logic [19:0]          sg_s2,
	output logic [15:0]          pan_s2,
	output logic [15:0]          cn_s2,
	output logic [27:0]          xr_s2,
	output logic [16:0]          lb_s2
);

	logic [c2r_pkg::SECW-1:0] sec_all;
	logic [7:0]  lum_dist;
	logic [5:0]  ca [3];
	logic [5:0]  ce [3];
	logic [7:0]  inv_ratio;

	logic [1:0]  op_s1;
	logic [15:0] hue_s1;
	logic        oob_s1;
	logic [c2r_pkg::SECW-1:0] sec_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  bri_s1;
	logic [15:0] cn_s1;
	logic [13:0] ma_s1 [3];
	logic [13:0] me_s1 [3];

	always_comb begin
		sec_all = '0;
		for (int k = 1; k <= c2r_pkg::SEC_MAX; k++) begin
			if (hue >= 16'(k * c2r_pkg::HUE_UNIT)) begin
				sec_all = c2r_pkg::SECW'(k);
			end
		end
		if (brightness[7]) begin
			lum_dist = 8'({brightness, 1'b0} - 9'd255);
		end else begin
			lum_dist = 8'(9'd255 - {brightness, 1'b0});
		end
		ca[0] = {1'b0, base_color[15:11]};
		ca[1] = base_color[10:5];
		ca[2] = {1'b0, base_color[4:0]};
		ce[0] = {1'b0, extra_color[15:11]};
		ce[1] = extra_color[10:5];
		ce[2] = {1'b0, extra_color[4:0]};
		inv_ratio = 8'd255 - mix_ratio;
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			op_s1  <= opcode;
			hue_s1 <= hue;
			oob_s1 <= hue >= 16'(c2r_pkg::HUE_WRAP);
			sec_s1 <= sec_all;
			sat_s1 <= saturation;
			bri_s1 <= brightness;
			cn_s1  <= 16'(8'd255 - lum_dist) * 16'(saturation);
			for (int i = 0; i < 3; i++) begin
				ma_s1[i] <= 14'(ca[i]) * 14'(inv_ratio);
				me_s1[i] <= 14'(ce[i]) * 14'(mix_ratio);
			end
		end
	end

	logic [c2r_pkg::FRACW-1:0] frac;
	logic [c2r_pkg::FRACW-1:0] frac_hsv;
	logic [c2r_pkg::FRACW-1:0] ramp;
	logic [2:0]  sec_hsv;
	logic [2:0]  sec_hsl;
	logic [7:0]  mch [3];
	logic [15:0] sec_base;

	always_comb begin
		sec_base = 16'(sec_s1) * 16'(c2r_pkg::HUE_UNIT);
		frac     = c2r_pkg::FRACW'(hue_s1 - sec_base);
		frac_hsv = oob_s1 ? '0 : frac;
		sec_hsv  = oob_s1 ? 3'd0 : sec_s1[2:0];
		sec_hsl  = (sec_s1 >= c2r_pkg::SECW'(c2r_pkg::SEC_LAST)) ? c2r_pkg::SEC_LAST
		                                                          : sec_s1[2:0];
		ramp     = sec_s1[0] ? c2r_pkg::FRACW'(c2r_pkg::HUE_UNIT - 32'(frac)) : frac;
		for (int i = 0; i < 3; i++) begin
			mch[i] = c2r_pkg::div255(16'(ma_s1[i])) + c2r_pkg::div255(16'(me_s1[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			ctl_s2.op  <= op_s1;
			ctl_s2.sec <= (op_s1 == c2r_pkg::OP_HSL) ? sec_hsl : sec_hsv;
			ctl_s2.val <= bri_s1;
			ctl_s2.mix <= {mch[0][4:0], mch[1][5:0], mch[2][4:0]};
			sf_s2  <= 20'(sat_s1) * 20'(frac_hsv);
			sg_s2  <= 20'(sat_s1) * 20'(c2r_pkg::FRACW'(c2r_pkg::HUE_UNIT - 32'(frac_hsv)));
			pan_s2 <= 16'(bri_s1) * 16'(8'd255 - sat_s1);
			cn_s2  <= cn_s1;
			xr_s2  <= 28'(cn_s1) * 28'(ramp);
			lb_s2  <= 17'(17'(bri_s1) * 17'd510 - 17'(cn_s1));
		end
	end

endmodule
`default_nettype wire

### sv/c2r_numer.sv
// Third pipeline stage: channel numerators routed onto the three shared dividers.
`default_nettype none
module c2r_numer (
	input  logic                        clk,
	input  logic                        ld3,
	input  c2r_pkg::c2r_ctl_t           ctl_s2,
	input  logic [19:0]                 sf_s2,
	input  logic [19:0]                 sg_s2,
	input  logic [15:0]                 pan_s2,
	input  logic [15:0]                 cn_s2,
	input  logic [27:0]                 xr_s2,
	input  logic [16:0]                 lb_s2,
	output c2r_pkg::c2r_ctl_t           ctl_s3,
	output logic [7:0]                  pa_s3,
	output logic [c2r_pkg::DIVW-1:0]    dx_s3 [3]
);

	logic [19:0] dd;
	logic [19:0] dc;
	logic [27:0] nd;
	logic [27:0] nc;
	logic [29:0] n_off;
	logic [29:0] n_ramp;
	logic [29:0] n_chroma;
	logic [c2r_pkg::DIVW-1:0] dx [3];

	always_comb begin
		dd       = 20'(c2r_pkg::HSV_DEN) - sf_s2;
		dc       = 20'(c2r_pkg::HSV_DEN) - sg_s2;
		nd       = 28'(ctl_s2.val) * 28'(dd);
		nc       = 28'(ctl_s2.val) * 28'(dc);
		n_off    = 30'(lb_s2) * 30'(c2r_pkg::HUE_UNIT);
		n_ramp   = n_off + 30'({xr_s2, 1'b0});
		n_chroma = n_off + 30'(cn_s2) * 30'(2 * c2r_pkg::HUE_UNIT);
		if (ctl_s2.op == c2r_pkg::OP_HSL) begin
			dx[0] = c2r_pkg::DIVW'(n_off >> c2r_pkg::HSL_PRE_SHIFT);
			dx[1] = c2r_pkg::DIVW'(n_ramp >> c2r_pkg::HSL_PRE_SHIFT);
			dx[2] = c2r_pkg::DIVW'(n_chroma >> c2r_pkg::HSL_PRE_SHIFT);
		end else begin
			dx[0] = c2r_pkg::DIVW'(nd >> c2r_pkg::HSV_PRE_SHIFT);
			dx[1] = c2r_pkg::DIVW'(nc >> c2r_pkg::HSV_PRE_SHIFT);
			dx[2] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			ctl_s3 <= ctl_s2;
			pa_s3  <= c2r_pkg::div255(pan_s2);
			for (int i = 0; i < 3; i++) begin
				dx_s3[i] <= dx[i];
			end
		end
	end

endmodule
`default_nettype wire

### sv/c2r_div.sv
// Fourth pipeline stage: reciprocal dividers with channel saturation.
`default_nettype none
module c2r_div (
	input  logic                        clk,
	input  logic                        ld4,
	input  c2r_pkg::c2r_ctl_t           ctl_s3,
	input  logic [7:0]                  pa_s3,
	input  logic [c2r_pkg::DIVW-1:0]    dx_s3 [3],
	output c2r_pkg::c2r_ctl_t           ctl_s4,
	output logic [7:0]                  pa_s4,
	output logic [7:0]                  ch_s4 [3]
);

	localparam int PW = c2r_pkg::DIVW + 23;
	localparam int QW = PW - c2r_pkg::RECIP_SHIFT;

	logic [PW-1:0] prod [3];
	logic [QW-1:0] quo  [3];
	logic [7:0]    sat  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = PW'(dx_s3[i]) * PW'(c2r_pkg::RECIP_CORE);
			quo[i]  = prod[i][PW-1:c2r_pkg::RECIP_SHIFT];
			sat[i]  = (quo[i] > QW'(255)) ? 8'd255 : quo[i][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			ctl_s4 <= ctl_s3;
			pa_s4  <= pa_s3;
			for (int i = 0; i < 3; i++) begin
				ch_s4[i] <= sat[i];
			end
		end
	end

endmodule
`default_nettype wire

### sv/color_to_rgb565_converter_core.sv
// Top level of the HSV, HSL and blend to RGB565 pixel converter.
//
// Requests enter on the s_axis channel: tuser carries the opcode (HSV, HSL
// or blend) and tdata carries hue, saturation, brightness, the two RGB565
// colors and the mix ratio. Each request yields exactly one RGB565 word on
// the m_axis channel, in request order.
// The datapath is a five-stage pipeline: sector and chroma, products,
// numerators, reciprocal division, channel routing and packing. A result
// passes through the stage registers in order to m_axis, and one request
// can be accepted every cycle while the receiver does not stall. The
// dividers and the multipliers in front of them set the stage depth.
// Each stage has its own valid bit and is loaded whenever it is empty or
// the stage after it moves, so a stalled receiver only holds back the
// requests queued behind it; empty stages still fill. Nothing is dropped
// or repeated under backpressure.
// Reset clears every valid bit; the pipeline is empty and ready right after.
`default_nettype none
`include "color_to_rgb565_converter_core_assert.svh"
module color_to_rgb565_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// hue[15:0], saturation[23:16], brightness[31:24], base_color[47:32],
	// extra_color[63:48], mix_ratio[71:64]
	input  logic [71:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rgb565[15:0]
	output logic [15:0] m_axis_tdata
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	c2r_pkg::c2r_ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [19:0] sf_s2, sg_s2;
	logic [15:0] pan_s2, cn_s2;
	logic [27:0] xr_s2;
	logic [16:0] lb_s2;
	logic [7:0]  pa_s3, pa_s4;
	logic [c2r_pkg::DIVW-1:0] dx_s3 [3];
	logic [7:0]  ch_s4 [3];
	logic [15:0] rgb_s5;
	logic [15:0] rgb_next;
	logic [7:0]  red, grn, blu;
	logic        rsvd_move;

	assign rdy5 = !vld_s5 || m_axis_tready;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = rgb_s5;

	assign rsvd_move = rdy5 && vld_s4 && (ctl_s4.op == c2r_pkg::OP_RSVD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_axis_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	c2r_front u_front (
		.clk         (clk),
		.ld1         (rdy1),
		.ld2         (rdy2),
		.opcode      (s_axis_tuser),
		.hue         (s_axis_tdata[15:0]),
		.saturation  (s_axis_tdata[23:16]),
		.brightness  (s_axis_tdata[31:24]),
		.base_color  (s_axis_tdata[47:32]),
		.extra_color (s_axis_tdata[63:48]),
		.mix_ratio   (s_axis_tdata[71:64]),
		.ctl_s2      (ctl_s2),
		.sf_s2       (sf_s2),
		.sg_s2       (sg_s2),
		.pan_s2      (pan_s2),
		.cn_s2       (cn_s2),
		.xr_s2       (xr_s2),
		.lb_s2       (lb_s2)
	);

	c2r_numer u_numer (
		.clk    (clk),
		.ld3    (rdy3),
		.ctl_s2 (ctl_s2),
		.sf_s2  (sf_s2),
		.sg_s2  (sg_s2),
		.pan_s2 (pan_s2),
		.cn_s2  (cn_s2),
		.xr_s2  (xr_s2),
		.lb_s2  (lb_s2),
		.ctl_s3 (ctl_s3),
		.pa_s3  (pa_s3),
		.dx_s3  (dx_s3)
	);

	c2r_div u_div (
		.clk    (clk),
		.ld4    (rdy4),
		.ctl_s3 (ctl_s3),
		.pa_s3  (pa_s3),
		.dx_s3  (dx_s3),
		.ctl_s4 (ctl_s4),
		.pa_s4  (pa_s4),
		.ch_s4  (ch_s4)
	);

	// For HSV the dividers hold the falling and rising ramps; for HSL they
	// hold the offset-only, ramp and chroma channel values.
	always_comb begin
		red = '0;
		grn = '0;
		blu = '0;
		if (ctl_s4.op == c2r_pkg::OP_HSL) begin
			unique case (ctl_s4.sec)
				3'd0: begin red = ch_s4[2]; grn = ch_s4[1]; blu = ch_s4[0]; end
				3'd1: begin red = ch_s4[1]; grn = ch_s4[2]; blu = ch_s4[0]; end
				3'd2: begin red = ch_s4[0]; grn = ch_s4[2]; blu = ch_s4[1]; end
				3'd3: begin red = ch_s4[0]; grn = ch_s4[1]; blu = ch_s4[2]; end
				3'd4: begin red = ch_s4[1]; grn = ch_s4[0]; blu = ch_s4[2]; end
				default: begin red = ch_s4[2]; grn = ch_s4[0]; blu = ch_s4[1]; end
			endcase
		end else begin
			unique case (ctl_s4.sec)
				3'd0: begin red = ctl_s4.val; grn = ch_s4[1]; blu = pa_s4; end
				3'd1: begin red = ch_s4[0]; grn = ctl_s4.val; blu = pa_s4; end
				3'd2: begin red = pa_s4; grn = ctl_s4.val; blu = ch_s4[1]; end
				3'd3: begin red = pa_s4; grn = ch_s4[0]; blu = ctl_s4.val; end
				3'd4: begin red = ch_s4[1]; grn = pa_s4; blu = ctl_s4.val; end
				default: begin red = ctl_s4.val; grn = pa_s4; blu = ch_s4[0]; end
			endcase
		end
		unique case (ctl_s4.op) inside
			c2r_pkg::OP_HSV, c2r_pkg::OP_HSL: rgb_next = {red[7:3], grn[7:2], blu[7:3]};
			c2r_pkg::OP_MIX: rgb_next = ctl_s4.mix;
			default: rgb_next = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			rgb_s5 <= rgb_next;
		end
	end

	`C2R_ASSERT(a_bubble_ready, !vld_s1 |-> s_axis_tready, "empty first stage refused a request")
	`C2R_ASSERT_NEXT(a_stall_keeps, vld_s4 && !rdy5, vld_s4, "request lost in a stalled stage")
	`C2R_ASSERT_NEXT(a_unused_zero, rsvd_move, m_axis_tdata == 16'h0000, "unused opcode not zero")

endmodule
`default_nettype wire
